// ----- design/drum_pkg.sv -----
// shared types and constants of the dense rank normalization block
package drum_pkg;

  localparam int VAL_W = 32;

  // control part of a token moving down the rank chain
  typedef struct packed {
    logic vld;
    logic is_query;
    logic last;
    logic ovf;
  } tok_ctl_t;

  // control part of a beat moving down the divider chain
  typedef struct packed {
    logic vld;
    logic last;
    logic ovf;
  } div_ctl_t;

endpackage

// ----- design/distinct_rank_uniform_map_top.sv -----
// top level of the dense rank normalization block: value store, rank chain, divider chain
// Values are taken one beat per cycle while the input is not stalled; the first MAX_ITEMS
// of a batch are kept in a value store and also sent down a chain of MAX_ITEMS cells that
// keeps each distinct value once. Later values of the batch are dropped and the batch is
// flagged as overflowed. After the beat with batch_end the input stalls while the store is
// read back in load order, one query per cycle unless the output stalls. Each query walks
// the cell chain and counts the distinct values below it and in total, then a 32-stage
// divider chain forms floor(0xFFFFFFFF * rank / count). Results leave at one beat per cycle
// while the output is not stalled. A stall on the output freezes the whole pipeline.
module distinct_rank_uniform_map_top #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [drum_pkg::VAL_W-1:0]     value_in_i,
  input  logic                           batch_end_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [drum_pkg::VAL_W-1:0]     mapped_value_o,
  output logic                           result_end_o,
  output logic                           overflowed_o
);
  import drum_pkg::*;

  localparam int CntW  = $clog2(MAX_ITEMS + 1);
  localparam int AddrW = $clog2(MAX_ITEMS);
  localparam int NumW  = CntW + VAL_W;

  logic             adv, in_acc, store, drop, close;
  logic [CntW-1:0]  ld_cnt_q, ld_cnt_inc;
  logic             ovf_q;
  logic             busy_q;
  logic [AddrW-1:0] rd_idx_q;
  logic [CntW-1:0]  emit_cnt_q;
  logic             emit_ovf_q;
  logic             issue_last;
  logic             pre_vld_q, pre_last_q, pre_ovf_q;
  logic [VAL_W-1:0] rd_data_q;
  logic [VAL_W-1:0] mem [MAX_ITEMS];

  tok_ctl_t         ch_ctl  [MAX_ITEMS+1];
  logic [VAL_W-1:0] ch_val  [MAX_ITEMS+1];
  logic [CntW-1:0]  ch_rank [MAX_ITEMS+1];
  logic [CntW-1:0]  ch_cnt  [MAX_ITEMS+1];

  div_ctl_t         dv_ctl  [VAL_W+1];
  logic [CntW-1:0]  dv_rem  [VAL_W+1];
  logic [VAL_W-1:0] dv_word [VAL_W+1];
  logic [CntW-1:0]  dv_div  [VAL_W+1];

  logic [NumW-1:0]  num;

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = busy_q || pre_vld_q || !adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign store      = in_acc && (ld_cnt_q != CntW'(MAX_ITEMS));
  assign drop       = in_acc && (ld_cnt_q == CntW'(MAX_ITEMS));
  assign close      = in_acc && batch_end_i;
  assign ld_cnt_inc = ld_cnt_q + CntW'(store);
  assign issue_last = ((CntW'(rd_idx_q) + CntW'(1)) == emit_cnt_q);

  // load bookkeeping and readback sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_cnt_q   <= '0;
      ovf_q      <= 1'b0;
      busy_q     <= 1'b0;
      rd_idx_q   <= '0;
      emit_cnt_q <= '0;
      emit_ovf_q <= 1'b0;
      pre_vld_q  <= 1'b0;
      pre_last_q <= 1'b0;
      pre_ovf_q  <= 1'b0;
    end else if (adv) begin
      if (close) begin
        ld_cnt_q   <= '0;
        ovf_q      <= 1'b0;
        busy_q     <= 1'b1;
        rd_idx_q   <= '0;
        emit_cnt_q <= ld_cnt_inc;
        emit_ovf_q <= ovf_q || drop;
      end else begin
        ld_cnt_q <= ld_cnt_inc;
        ovf_q    <= ovf_q || drop;
      end
      pre_vld_q  <= busy_q;
      pre_last_q <= busy_q && issue_last;
      pre_ovf_q  <= emit_ovf_q;
      if (busy_q) begin
        if (issue_last) begin
          busy_q <= 1'b0;
        end else begin
          rd_idx_q <= rd_idx_q + AddrW'(1);
        end
      end
    end
  end

  // value store in load order
  always_ff @(posedge clk_i) begin
    if (store) begin
      mem[ld_cnt_q[AddrW-1:0]] <= value_in_i;
    end
    if (adv) begin
      rd_data_q <= mem[rd_idx_q];
    end
  end

  // chain head: queries from the store, loads from the input
  always_comb begin
    ch_ctl[0]  = '0;
    ch_val[0]  = value_in_i;
    ch_rank[0] = '0;
    ch_cnt[0]  = '0;
    if (pre_vld_q) begin
      ch_ctl[0].vld      = 1'b1;
      ch_ctl[0].is_query = 1'b1;
      ch_ctl[0].last     = pre_last_q;
      ch_ctl[0].ovf      = pre_ovf_q;
      ch_val[0]          = rd_data_q;
    end else if (store) begin
      ch_ctl[0].vld = 1'b1;
    end
  end

  for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
    drum_cell #(
      .CNT_W (CntW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .ctl_i  (ch_ctl[g]),
      .val_i  (ch_val[g]),
      .rank_i (ch_rank[g]),
      .cnt_i  (ch_cnt[g]),
      .ctl_o  (ch_ctl[g+1]),
      .val_o  (ch_val[g+1]),
      .rank_o (ch_rank[g+1]),
      .cnt_o  (ch_cnt[g+1])
    );
  end

  // dividend 0xFFFFFFFF * rank as (rank << 32) - rank
  assign num = {ch_rank[MAX_ITEMS], {VAL_W{1'b0}}} - NumW'(ch_rank[MAX_ITEMS]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_ctl[0] <= '0;
    end else if (adv) begin
      dv_ctl[0].vld  <= ch_ctl[MAX_ITEMS].vld && ch_ctl[MAX_ITEMS].is_query;
      dv_ctl[0].last <= ch_ctl[MAX_ITEMS].last;
      dv_ctl[0].ovf  <= ch_ctl[MAX_ITEMS].ovf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_rem[0]  <= num[NumW-1:VAL_W];
      dv_word[0] <= num[VAL_W-1:0];
      dv_div[0]  <= ch_cnt[MAX_ITEMS];
    end
  end

  for (genvar s = 0; s < VAL_W; s++) begin : g_div
    drum_div_cell #(
      .CNT_W (CntW)
    ) u_div_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .ctl_i  (dv_ctl[s]),
      .rem_i  (dv_rem[s]),
      .word_i (dv_word[s]),
      .div_i  (dv_div[s]),
      .ctl_o  (dv_ctl[s+1]),
      .rem_o  (dv_rem[s+1]),
      .word_o (dv_word[s+1]),
      .div_o  (dv_div[s+1])
    );
  end

  assign out_valid_o    = dv_ctl[VAL_W].vld;
  assign mapped_value_o = dv_word[VAL_W];
  assign result_end_o   = dv_ctl[VAL_W].last;
  assign overflowed_o   = dv_ctl[VAL_W].ovf;

  a_emit_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (emit_cnt_q != '0))
    else $error("readback running on an empty batch");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_cnt_q <= CntW'(MAX_ITEMS))
    else $error("load count beyond capacity");

  a_busy_on_close : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> $past(in_valid_i && batch_end_i && !in_stall_o))
    else $error("readback started without a closing beat");

  a_divisor_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_ctl[0].vld |-> (dv_div[0] != '0))
    else $error("query left the chain with no distinct values");

endmodule

// ----- design/drum_cell.sv -----
// one cell of the rank chain: holds one distinct value, places loads, counts for queries
module drum_cell #(
  parameter int CNT_W = 7
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           adv_i,
  input  drum_pkg::tok_ctl_t             ctl_i,
  input  logic [drum_pkg::VAL_W-1:0]     val_i,
  input  logic [CNT_W-1:0]               rank_i,
  input  logic [CNT_W-1:0]               cnt_i,
  output drum_pkg::tok_ctl_t             ctl_o,
  output logic [drum_pkg::VAL_W-1:0]     val_o,
  output logic [CNT_W-1:0]               rank_o,
  output logic [CNT_W-1:0]               cnt_o
);
  import drum_pkg::*;

  logic             cell_vld_q, cell_vld_d;
  logic [VAL_W-1:0] cell_val_q, cell_val_d;
  tok_ctl_t         ctl_q, ctl_d;
  logic [VAL_W-1:0] val_q;
  logic [CNT_W-1:0] rank_q, rank_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             eq, lt;

  assign eq = (cell_val_q == val_i);
  assign lt = (cell_val_q < val_i);

  always_comb begin
    cell_vld_d = cell_vld_q;
    cell_val_d = cell_val_q;
    ctl_d      = ctl_i;
    rank_d     = rank_i;
    cnt_d      = cnt_i;
    if (ctl_i.vld) begin
      if (ctl_i.is_query) begin
        if (cell_vld_q) begin
          cnt_d = cnt_i + CNT_W'(1);
          if (lt) begin
            rank_d = rank_i + CNT_W'(1);
          end
        end
        // the final query of a batch empties the chain behind it
        if (ctl_i.last) begin
          cell_vld_d = 1'b0;
        end
      end else if (!cell_vld_q) begin
        cell_vld_d = 1'b1;
        cell_val_d = val_i;
        ctl_d.vld  = 1'b0;
      end else if (eq) begin
        ctl_d.vld = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_vld_q <= 1'b0;
      ctl_q      <= '0;
    end else if (adv_i) begin
      cell_vld_q <= cell_vld_d;
      ctl_q      <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cell_val_q <= cell_val_d;
      val_q      <= val_i;
      rank_q     <= rank_d;
      cnt_q      <= cnt_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign val_o  = val_q;
  assign rank_o = rank_q;
  assign cnt_o  = cnt_q;

endmodule

// ----- design/drum_div_cell.sv -----
// one stage of the divider chain: resolves one quotient bit
module drum_div_cell #(
  parameter int CNT_W = 7
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           adv_i,
  input  drum_pkg::div_ctl_t             ctl_i,
  input  logic [CNT_W-1:0]               rem_i,
  input  logic [drum_pkg::VAL_W-1:0]     word_i,
  input  logic [CNT_W-1:0]               div_i,
  output drum_pkg::div_ctl_t             ctl_o,
  output logic [CNT_W-1:0]               rem_o,
  output logic [drum_pkg::VAL_W-1:0]     word_o,
  output logic [CNT_W-1:0]               div_o
);
  import drum_pkg::*;

  div_ctl_t         ctl_q;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [VAL_W-1:0] word_q, word_d;
  logic [CNT_W-1:0] div_q;
  logic [CNT_W:0]   trial, diff;
  logic             ge;

  // word shifts dividend bits out at the top and quotient bits in at the bottom
  always_comb begin
    trial  = {rem_i, word_i[VAL_W-1]};
    diff   = trial - {1'b0, div_i};
    ge     = (trial >= {1'b0, div_i});
    rem_d  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    word_d = {word_i[VAL_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rem_q  <= rem_d;
      word_q <= word_d;
      div_q  <= div_i;
    end
  end

  assign ctl_o  = ctl_q;
  assign rem_o  = rem_q;
  assign word_o = word_q;
  assign div_o  = div_q;

endmodule

// ----- bench/tb_distinct_rank_uniform_map_top.sv -----
// self-checking testbench of the dense rank normalization block
module tb_distinct_rank_uniform_map_top;

  localparam int VW           = drum_pkg::VAL_W;
  localparam int MAX_ITEMS    = 64;
  localparam int HALF_PERIOD  = 2;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ITEMS = 80;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = MAX_ITEMS + 48;
  localparam int N_DIRECTED   = 19;
  localparam logic [63:0] FULL_SCALE = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic [VW-1:0] mapped;
    logic          last;
    logic          ovf;
  } mapped_beat_t;

  typedef struct packed {
    logic [VW-1:0] value;
    logic          fin;
    logic          typed;
    mapped_beat_t  beat;
  } stim_row_t;

  localparam mapped_beat_t NO_BEAT = '0;

  logic          clk_i          = 1'b0;
  logic          rst_ni         = 1'b0;
  logic          in_valid_i     = 1'b0;
  logic          in_stall_o;
  logic [VW-1:0] value_in_i     = '0;
  logic          batch_end_i    = 1'b0;
  logic          out_valid_o;
  logic          out_stall_i    = 1'b0;
  logic [VW-1:0] mapped_value_o;
  logic          result_end_o;
  logic          overflowed_o;

  // typed beats only where the answer is obvious
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{32'h0000_0000, 1'b1, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
    '{32'hFFFF_FFFF, 1'b0, 1'b1, '{32'h7FFF_FFFF, 1'b0, 1'b0}},
    '{32'h0000_0000, 1'b1, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
    '{32'h0000_0007, 1'b0, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
    '{32'h0000_0007, 1'b0, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
    '{32'h0000_0007, 1'b1, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
    '{32'h0000_0003, 1'b0, 1'b0, NO_BEAT},
    '{32'h0000_0001, 1'b0, 1'b0, NO_BEAT},
    '{32'h0000_0002, 1'b0, 1'b0, NO_BEAT},
    '{32'h0000_0001, 1'b1, 1'b0, NO_BEAT},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, NO_BEAT},
    '{32'h5555_5555, 1'b0, 1'b0, NO_BEAT},
    '{32'h8000_0000, 1'b0, 1'b0, NO_BEAT},
    '{32'h7FFF_FFFF, 1'b1, 1'b0, NO_BEAT},
    '{32'hFFFF_FFFE, 1'b0, 1'b0, NO_BEAT},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, NO_BEAT},
    '{32'h0000_0001, 1'b0, 1'b0, NO_BEAT},
    '{32'h0000_0000, 1'b1, 1'b0, NO_BEAT}
  };

  stim_row_t    held_rows [$];
  logic         batch_ovf     = 1'b0;
  mapped_beat_t rank_map_q [$];

  int  fail_count     = 0;
  int  batches_closed = 0;
  int  ovf_batches    = 0;
  int  values_loaded  = 0;
  int  beats_checked  = 0;
  int  idle_cycles    = 0;
  bit  tx_busy        = 1'b0;
  bit  rx_busy        = 1'b0;
  bit  squeeze_req    = 1'b0;

  distinct_rank_uniform_map_top #(
    .MAX_ITEMS(MAX_ITEMS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .value_in_i    (value_in_i),
    .batch_end_i   (batch_end_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .mapped_value_o(mapped_value_o),
    .result_end_o  (result_end_o),
    .overflowed_o  (overflowed_o)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // store the value, and on batch close queue one scaled rank per stored value
  function automatic void load_value(input stim_row_t row);
    logic [VW-1:0] ladder [$];
    int            pos;
    logic [63:0]   scaled;
    mapped_beat_t  beat;
    if (held_rows.size() < MAX_ITEMS) begin
      held_rows.push_back(row);
    end else begin
      batch_ovf = 1'b1;
    end
    if (row.fin) begin
      foreach (held_rows[i]) begin
        pos = 0;
        while (pos < ladder.size() && ladder[pos] < held_rows[i].value) pos++;
        if (pos == ladder.size() || ladder[pos] != held_rows[i].value) begin
          ladder.insert(pos, held_rows[i].value);
        end
      end
      foreach (held_rows[i]) begin
        pos = 0;
        while (ladder[pos] < held_rows[i].value) pos++;
        scaled      = (FULL_SCALE * 64'(pos)) / 64'(ladder.size());
        beat.mapped = scaled[VW-1:0];
        beat.last   = (i == held_rows.size() - 1);
        beat.ovf    = batch_ovf;
        rank_map_q.push_back(held_rows[i].typed ? held_rows[i].beat : beat);
      end
      batches_closed++;
      if (batch_ovf) ovf_batches++;
      held_rows.delete();
      batch_ovf = 1'b0;
    end
  endfunction

  task automatic offer_value(input stim_row_t row);
    int gap;
    gap = tx_busy ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    value_in_i  <= row.value;
    batch_end_i <= row.fin;
    do @(posedge clk_i); while (in_stall_o);
    load_value(row);
    values_loaded++;
  endtask

  initial begin : stimulus
    stim_row_t     row;
    logic [VW-1:0] v;
    logic [VW-1:0] base;
    int            size;
    int            random_items;
    random_items = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < N_DIRECTED; r++) begin
      tx_busy = (r >= 7);
      offer_value(directed_rows[r]);
    end

    for (int b = 0; b < 5 || random_items < RANDOM_ITEMS; b++) begin
      tx_busy = ($urandom_range(0, 3) != 0);
      if (b == 2) begin
        // overfull batch sent back to back while the output is held off
        size        = MAX_ITEMS + $urandom_range(1, 3);
        tx_busy     = 1'b0;
        squeeze_req = 1'b1;
      end else begin
        size = $urandom_range(1, 12);
      end
      base = $urandom;
      v    = '0;
      for (int k = 0; k < size; k++) begin
        case ($urandom_range(0, 3))
          0:       v = $urandom;
          1:       v = base + $urandom_range(0, 5);
          2:       v = (k > 0) ? v : $urandom;
          default: v = $urandom_range(0, 1) ? '1 : '0;
        endcase
        row = '{v, (k == size - 1), 1'b0, NO_BEAT};
        offer_value(row);
        random_items++;
      end
    end
    in_valid_i <= 1'b0;

    while (rank_map_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d batches (%0d with dropped values), %0d values loaded",
             batches_closed, ovf_batches, values_loaded);
    $display("checked %0d result beats, %0d mismatches", beats_checked, fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : drain
    int gap;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_busy = !rx_busy;
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        gap = HOLD_CYCLES;
      end else begin
        gap = rx_busy ? $urandom_range(0, 16) : 0;
      end
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o && !squeeze_req);
    end
  end

  always @(posedge clk_i) begin
    mapped_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (rank_map_q.size() == 0) begin
        $error("result beat with nothing pending: mapped_value %h", mapped_value_o);
        fail_count++;
      end else begin
        want = rank_map_q.pop_front();
        beats_checked++;
        if (mapped_value_o !== want.mapped) begin
          $error("mapped_value mismatch: expected %h, got %h", want.mapped, mapped_value_o);
          fail_count++;
        end
        if (result_end_o !== want.last) begin
          $error("result_end mismatch: expected %b, got %b", want.last, result_end_o);
          fail_count++;
        end
        if (overflowed_o !== want.ovf) begin
          $error("overflowed mismatch: expected %b, got %b", want.ovf, overflowed_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
